// ===== rtl/ntc_counts_to_temperature_defines.svh =====
// ----------------------------------------------------------------------------
// NTC conversion assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef NTC_COUNTS_TO_TEMPERATURE_DEFINES_SVH
`define NTC_COUNTS_TO_TEMPERATURE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTC_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("ntc conversion assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NTC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("ntc conversion assertion failed");

`endif

// ===== rtl/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// NTC conversion package
// Types and fixed constants shared by the thermistor conversion modules.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int unsigned AdcW      = 16;
  localparam int unsigned ResW      = 20;
  localparam int unsigned ProdW     = 36;
  localparam int unsigned PosW      = 6;
  localparam int unsigned MantW     = 31;
  localparam int unsigned FracBits  = 24;
  localparam int unsigned LogW      = 30;
  localparam int unsigned NmrBaseW  = 37;
  localparam int unsigned BetaX100W = 21;
  localparam int unsigned DnmW      = 48;
  localparam int unsigned RemW      = 64;
  localparam int unsigned QuotW     = 16;
  localparam int unsigned TempW     = 16;
  localparam int unsigned FifoDepth = 4;

  localparam logic [AdcW-1:0] RailGuard = 16'd2;
  localparam logic [LogW-1:0] Ln2Q30    = 30'd744261118;
  localparam logic [QuotW-1:0] KelvinOffset = 16'd27315;
  localparam logic [QuotW-1:0] TkMin    = 16'd23315;
  localparam logic [QuotW-1:0] TkMax    = 16'd42315;
  localparam logic signed [TempW-1:0] TempMin = -16'sd4000;
  localparam logic signed [TempW-1:0] TempMax = 16'sd15000;

  typedef enum logic [2:0] {
    REG_FULL_SCALE = 3'd0,
    REG_OPEN_TEMP  = 3'd1,
    REG_LOW_SIDE   = 3'd2,
    REG_FIXED_RES  = 3'd3,
    REG_NOM_TEMP   = 3'd4,
    REG_BETA       = 3'd5,
    REG_NOM_RES    = 3'd6,
    REG_UNUSED     = 3'd7
  } ntc_reg_e;

  typedef enum logic [1:0] {
    CLS_CONV  = 2'd0,
    CLS_FAULT = 2'd1,
    CLS_HOT   = 2'd2,
    CLS_COLD  = 2'd3
  } ntc_cls_e;

  typedef struct packed {
    logic [AdcW-1:0]          adc_full_scale;
    logic signed [TempW-1:0]  open_temp_centi;
    logic                     low_side;
    logic [ResW-1:0]          fixed_res;
    logic [15:0]              t0;
    logic [13:0]              beta;
    logic [ResW-1:0]          r25;
    logic [NmrBaseW-1:0]      nmr_base;
    logic [BetaX100W-1:0]     beta_x100;
  } ntc_regs_t;

  typedef struct packed {
    logic             fault;
    logic [ProdW-1:0] num;
    logic [ProdW-1:0] den;
  } ntc_item_t;

endpackage

// ===== rtl/ntc_stream_if.sv =====
// ----------------------------------------------------------------------------
// NTC stream interfaces
// Valid/ready channels for ADC counts in and temperatures out.
// ----------------------------------------------------------------------------
interface ntc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] adc_count;

  modport source (output valid, output adc_count, input ready);
  modport sink (input valid, input adc_count, output ready);
endinterface

interface ntc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_centi_c;
  logic               sensor_fault;

  modport source (output valid, output temp_centi_c, output sensor_fault, input ready);
  modport sink (input valid, input temp_centi_c, input sensor_fault, output ready);
endinterface

// ===== rtl/ntc_cfg.sv =====
// ----------------------------------------------------------------------------
// NTC configuration registers
// APB register file plus products of the beta model that depend on it alone.
// ----------------------------------------------------------------------------
module ntc_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ntc_pkg::ntc_regs_t cfg_o
);

  logic [15:0] full_q;
  logic [15:0] open_q;
  logic        low_q;
  logic [19:0] rf_q;
  logic [15:0] t0_q;
  logic [13:0] beta_q;
  logic [19:0] r25_q;
  logic [29:0] tb_q;
  logic [36:0] nmr_q;
  logic [20:0] bx_q;
  logic        wr_en;
  ntc_pkg::ntc_reg_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = ntc_pkg::ntc_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 16'd4095;
      open_q <= 16'd15000;
      low_q  <= 1'b1;
      rf_q   <= 20'd10000;
      t0_q   <= 16'd29815;
      beta_q <= 14'd3380;
      r25_q  <= 20'd10000;
    end else if (wr_en) begin
      unique case (sel)
        ntc_pkg::REG_FULL_SCALE: full_q <= pwdata[15:0];
        ntc_pkg::REG_OPEN_TEMP:  open_q <= pwdata[15:0];
        ntc_pkg::REG_LOW_SIDE:   low_q  <= pwdata[0];
        ntc_pkg::REG_FIXED_RES:  rf_q   <= pwdata[19:0];
        ntc_pkg::REG_NOM_TEMP:   t0_q   <= pwdata[15:0];
        ntc_pkg::REG_BETA:       beta_q <= pwdata[13:0];
        ntc_pkg::REG_NOM_RES:    r25_q  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    tb_q  <= 30'(t0_q) * 30'(beta_q);
    nmr_q <= 37'(tb_q) * 37'd100;
    bx_q  <= 21'(beta_q) * 21'd100;
  end

  always_comb begin
    unique case (sel)
      ntc_pkg::REG_FULL_SCALE: prdata = {16'd0, full_q};
      ntc_pkg::REG_OPEN_TEMP:  prdata = {16'd0, open_q};
      ntc_pkg::REG_LOW_SIDE:   prdata = {31'd0, low_q};
      ntc_pkg::REG_FIXED_RES:  prdata = {12'd0, rf_q};
      ntc_pkg::REG_NOM_TEMP:   prdata = {16'd0, t0_q};
      ntc_pkg::REG_BETA:       prdata = {18'd0, beta_q};
      ntc_pkg::REG_NOM_RES:    prdata = {12'd0, r25_q};
      default:                 prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg_o.adc_full_scale  = full_q;
    cfg_o.open_temp_centi = $signed(open_q);
    cfg_o.low_side        = low_q;
    cfg_o.fixed_res       = rf_q;
    cfg_o.t0              = t0_q;
    cfg_o.beta            = beta_q;
    cfg_o.r25             = r25_q;
    cfg_o.nmr_base        = nmr_q;
    cfg_o.beta_x100       = bx_q;
  end

endmodule

// ===== rtl/ntc_front.sv =====
// ----------------------------------------------------------------------------
// NTC front stage
// Accepts ADC counts, applies the rail guard and forms the resistance ratio.
// ----------------------------------------------------------------------------
module ntc_front #(
  parameter int unsigned CountBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ntc_pkg::ntc_regs_t cfg_i,
  ntc_in_if.sink             in_i,
  input  logic               full_i,
  output logic               push_o,
  output ntc_pkg::ntc_item_t item_o
);

  logic                     v_q;
  ntc_pkg::ntc_item_t       item_q;
  ntc_pkg::ntc_item_t       item_d;
  logic [CountBits-1:0]     cnt;
  logic [15:0]              c;
  logic [15:0]              diff;
  logic [15:0]              mul_a;
  logic [15:0]              mul_b;
  logic [19:0]              r25;
  logic                     rail;

  assign in_i.ready = !v_q || !full_i;
  assign push_o     = v_q && !full_i;
  assign item_o     = item_q;

  always_comb begin
    cnt  = in_i.adc_count[CountBits-1:0];
    c    = 16'(cnt);
    diff = cfg_i.adc_full_scale - c;
    rail = (c <= ntc_pkg::RailGuard) ||
           ((17'(c) + 17'(ntc_pkg::RailGuard)) >= 17'(cfg_i.adc_full_scale));
    r25  = (cfg_i.r25 == 20'd0) ? 20'd1 : cfg_i.r25;
    mul_a = cfg_i.low_side ? c : diff;
    mul_b = cfg_i.low_side ? diff : c;
    item_d.fault = rail || (cfg_i.fixed_res == 20'd0);
    item_d.num   = 36'(cfg_i.fixed_res) * 36'(mul_a);
    item_d.den   = 36'(r25) * 36'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_i.ready) begin
      v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/ntc_fifo.sv =====
// ----------------------------------------------------------------------------
// NTC item queue
// Short queue that decouples the front stage from the conversion pipeline.
// ----------------------------------------------------------------------------
module ntc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ntc_pkg::ntc_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output ntc_pkg::ntc_item_t item_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = $clog2(ntc_pkg::FifoDepth);

  ntc_pkg::ntc_item_t mem_q [ntc_pkg::FifoDepth];
  logic [PtrW-1:0]    wr_q;
  logic [PtrW-1:0]    rd_q;
  logic [PtrW:0]      cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(ntc_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/ntc_back.sv =====
// ----------------------------------------------------------------------------
// NTC conversion pipeline
// Log2 by repeated squaring, beta model denominator and a restoring divider.
// ----------------------------------------------------------------------------
module ntc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ntc_pkg::ntc_regs_t cfg_i,
  input  logic               empty_i,
  input  ntc_pkg::ntc_item_t item_i,
  output logic               pop_o,
  ntc_out_if.source          out_o
);

  localparam int unsigned NumSq = ntc_pkg::FracBits;
  localparam int unsigned NumDv = ntc_pkg::QuotW;

  function automatic logic [ntc_pkg::PosW-1:0] msb_pos(input logic [ntc_pkg::ProdW-1:0] x);
    logic [ntc_pkg::PosW-1:0] p;
    p = '0;
    for (int i = 0; i < ntc_pkg::ProdW; i++) begin
      if (x[i]) begin
        p = ntc_pkg::PosW'(i);
      end
    end
    return p;
  endfunction

  logic adv;

  // Leading-one stage.
  logic                      v1_q;
  ntc_pkg::ntc_cls_e         cls1_q;
  logic [ntc_pkg::ProdW-1:0] num1_q, den1_q;
  logic [ntc_pkg::PosW-1:0]  pn1_q, pd1_q;

  // Squaring chain; entry zero holds the normalized mantissas.
  logic                      sq_v_q   [NumSq+1];
  ntc_pkg::ntc_cls_e         sq_cls_q [NumSq+1];
  logic [ntc_pkg::MantW-1:0] sq_mn_q  [NumSq+1];
  logic [ntc_pkg::MantW-1:0] sq_md_q  [NumSq+1];
  logic [ntc_pkg::LogW-1:0]  sq_ln_q  [NumSq+1];
  logic [ntc_pkg::LogW-1:0]  sq_ld_q  [NumSq+1];

  logic                      va_q, vb_q, vc_q, vd_q, ve_q, vg_q;
  ntc_pkg::ntc_cls_e         clsa_q, clsb_q, clsc_q, clsd_q, clse_q;
  logic                      nega_q, negb_q;
  logic [ntc_pkg::LogW-1:0]  maga_q;
  logic [59:0]               prodb_q;
  logic signed [30:0]        lnqc_q;
  logic signed [47:0]        tld_q;
  logic [46:0]               dnme_q;
  logic [ntc_pkg::RemW-1:0]  ne_q;

  // Divider chain; entry zero holds the overflow-checked dividend.
  logic                      dv_v_q   [NumDv+1];
  ntc_pkg::ntc_cls_e         dv_cls_q [NumDv+1];
  logic [46:0]               dv_dnm_q [NumDv+1];
  logic [ntc_pkg::RemW-1:0]  dv_rem_q [NumDv+1];
  logic [ntc_pkg::QuotW-1:0] dv_q_q   [NumDv+1];

  logic signed [ntc_pkg::TempW-1:0] temp_q;
  logic                             fault_q;

  logic [ntc_pkg::ProdW-1:0] nrm_n, nrm_d;
  logic signed [30:0]        diff_a;
  logic [59:0]               rnd_c;
  logic [ntc_pkg::LogW-1:0]  mag_c;
  logic signed [47:0]        dnm_e;
  ntc_pkg::ntc_cls_e         cls_e;
  ntc_pkg::ntc_cls_e         cls_f;
  logic signed [ntc_pkg::TempW-1:0] temp_d;
  logic [ntc_pkg::QuotW-1:0] qf;

  assign adv   = !vg_q || out_o.ready;
  assign pop_o = adv && !empty_i;

  assign out_o.valid        = vg_q;
  assign out_o.temp_centi_c = temp_q;
  assign out_o.sensor_fault = fault_q;

  always_comb begin
    nrm_n  = num1_q << (ntc_pkg::PosW'(35) - pn1_q);
    nrm_d  = den1_q << (ntc_pkg::PosW'(35) - pd1_q);
    diff_a = $signed({1'b0, sq_ln_q[NumSq]}) - $signed({1'b0, sq_ld_q[NumSq]});
    rnd_c  = prodb_q + 60'(1 << 29);
    mag_c  = rnd_c[59:30];
    dnm_e  = $signed(48'(cfg_i.beta_x100) << ntc_pkg::FracBits) + tld_q;
    cls_e  = clsd_q;
    if (clsd_q == ntc_pkg::CLS_CONV) begin
      if (dnm_e == 48'sd0) begin
        cls_e = ntc_pkg::CLS_HOT;
      end else if (dnm_e[47]) begin
        cls_e = ntc_pkg::CLS_COLD;
      end
    end
    cls_f = clse_q;
    if ((clse_q == ntc_pkg::CLS_CONV) && (ne_q[63:16] >= 48'(dnme_q))) begin
      cls_f = ntc_pkg::CLS_HOT;
    end
    qf = dv_q_q[NumDv];
    unique case (dv_cls_q[NumDv])
      ntc_pkg::CLS_FAULT: temp_d = cfg_i.open_temp_centi;
      ntc_pkg::CLS_HOT:   temp_d = ntc_pkg::TempMax;
      ntc_pkg::CLS_COLD:  temp_d = ntc_pkg::TempMin;
      default: begin
        if (qf < ntc_pkg::TkMin) begin
          temp_d = ntc_pkg::TempMin;
        end else if (qf > ntc_pkg::TkMax) begin
          temp_d = ntc_pkg::TempMax;
        end else begin
          temp_d = $signed(qf - ntc_pkg::KelvinOffset);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      sq_v_q[0] <= 1'b0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      vc_q      <= 1'b0;
      vd_q      <= 1'b0;
      ve_q      <= 1'b0;
      dv_v_q[0] <= 1'b0;
      vg_q      <= 1'b0;
    end else if (adv) begin
      v1_q      <= !empty_i;
      sq_v_q[0] <= v1_q;
      va_q      <= sq_v_q[NumSq];
      vb_q      <= va_q;
      vc_q      <= vb_q;
      vd_q      <= vc_q;
      ve_q      <= vd_q;
      dv_v_q[0] <= ve_q;
      vg_q      <= dv_v_q[NumDv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls1_q <= item_i.fault ? ntc_pkg::CLS_FAULT : ntc_pkg::CLS_CONV;
      num1_q <= item_i.num;
      den1_q <= item_i.den;
      pn1_q  <= msb_pos(item_i.num);
      pd1_q  <= msb_pos(item_i.den);

      sq_cls_q[0] <= cls1_q;
      sq_mn_q[0]  <= nrm_n[35:5];
      sq_md_q[0]  <= nrm_d[35:5];
      sq_ln_q[0]  <= {pn1_q, {ntc_pkg::FracBits{1'b0}}};
      sq_ld_q[0]  <= {pd1_q, {ntc_pkg::FracBits{1'b0}}};

      clsa_q <= sq_cls_q[NumSq];
      nega_q <= diff_a[30];
      maga_q <= diff_a[30] ? ntc_pkg::LogW'(-diff_a) : ntc_pkg::LogW'(diff_a);

      clsb_q  <= clsa_q;
      negb_q  <= nega_q;
      prodb_q <= 60'(maga_q) * 60'(ntc_pkg::Ln2Q30);

      clsc_q <= clsb_q;
      lnqc_q <= negb_q ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

      clsd_q <= clsc_q;
      tld_q  <= 48'($signed({1'b0, cfg_i.t0})) * 48'(lnqc_q);

      clse_q <= cls_e;
      dnme_q <= dnm_e[46:0];
      ne_q   <= (ntc_pkg::RemW'(cfg_i.nmr_base) << ntc_pkg::FracBits) +
                ntc_pkg::RemW'(dnm_e[46:1]);

      dv_cls_q[0] <= cls_f;
      dv_dnm_q[0] <= dnme_q;
      dv_rem_q[0] <= ne_q;
      dv_q_q[0]   <= '0;

      temp_q  <= temp_d;
      fault_q <= (dv_cls_q[NumDv] == ntc_pkg::CLS_FAULT);
    end
  end

  for (genvar i = 0; i < NumSq; i++) begin : g_sq
    logic [61:0]               sqn, sqd;
    logic [ntc_pkg::MantW-1:0] mn_d, md_d;
    logic [ntc_pkg::LogW-1:0]  ln_d, ld_d;

    always_comb begin
      sqn  = 62'(sq_mn_q[i]) * 62'(sq_mn_q[i]);
      sqd  = 62'(sq_md_q[i]) * 62'(sq_md_q[i]);
      ln_d = sq_ln_q[i];
      ld_d = sq_ld_q[i];
      if (sqn[61]) begin
        mn_d = sqn[61:31];
        ln_d[NumSq-1-i] = 1'b1;
      end else begin
        mn_d = sqn[60:30];
      end
      if (sqd[61]) begin
        md_d = sqd[61:31];
        ld_d[NumSq-1-i] = 1'b1;
      end else begin
        md_d = sqd[60:30];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[i+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[i+1] <= sq_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_cls_q[i+1] <= sq_cls_q[i];
        sq_mn_q[i+1]  <= mn_d;
        sq_md_q[i+1]  <= md_d;
        sq_ln_q[i+1]  <= ln_d;
        sq_ld_q[i+1]  <= ld_d;
      end
    end
  end

  for (genvar j = 0; j < NumDv; j++) begin : g_dv
    localparam int unsigned K = NumDv - 1 - j;
    logic [ntc_pkg::RemW-1:0]  sh;
    logic [ntc_pkg::RemW-1:0]  rem_d;
    logic [ntc_pkg::QuotW-1:0] q_d;

    always_comb begin
      sh    = ntc_pkg::RemW'(dv_dnm_q[j]) << K;
      rem_d = dv_rem_q[j];
      q_d   = dv_q_q[j];
      if (dv_rem_q[j] >= sh) begin
        rem_d  = dv_rem_q[j] - sh;
        q_d[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_cls_q[j+1] <= dv_cls_q[j];
        dv_dnm_q[j+1] <= dv_dnm_q[j];
        dv_rem_q[j+1] <= rem_d;
        dv_q_q[j+1]   <= q_d;
      end
    end
  end

endmodule

// ===== rtl/ntc_counts_to_temperature.sv =====
// ----------------------------------------------------------------------------
// NTC counts to temperature
// Converts thermistor divider ADC counts to temperature in 0.01 degC.
// ----------------------------------------------------------------------------
// The block takes one ADC count per cycle while its input queue has room and
// returns one temperature per count, in order. The pipeline holds the 24
// squaring stages of the two log2 units and the 16 stages of the restoring
// divider; a four-entry queue sits between the input stage and the
// conversion pipeline, so the input takes up to five more counts while a
// result waits on the output before it closes.
// Counts near either rail, or a zero fixed resistor, return the programmed
// fail-safe temperature with sensor_fault set. Registers are written over APB
// at byte address 4*i and should only be changed while no conversion is open.
module ntc_counts_to_temperature #(
  parameter int unsigned CountBits = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ntc_in_if.sink      in_i,
  ntc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ntc_pkg::ntc_regs_t cfg;
  ntc_pkg::ntc_item_t push_item;
  ntc_pkg::ntc_item_t pop_item;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;

  ntc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ntc_front #(.CountBits(CountBits)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  ntc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  ntc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .empty_i (empty),
    .item_i  (pop_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== rtl/ntc_checker.sv =====
// ----------------------------------------------------------------------------
// NTC port checker
// Port-level assertions on output hold, occupancy and output range.
// ----------------------------------------------------------------------------
`include "ntc_counts_to_temperature_defines.svh"

module ntc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic signed [15:0] out_temp_i,
  input logic        out_fault_i
);

  logic [7:0] pend_q;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = in_valid_i && in_ready_i;
  assign acc_out = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (acc_in && !acc_out) begin
      pend_q <= pend_q + 1'b1;
    end else if (acc_out && !acc_in) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  `NTC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `NTC_ASSERT_IMPL(a_no_spurious, out_valid_i, pend_q != 8'd0)
  `NTC_ASSERT_IMPL(a_ready_when_empty, pend_q == 8'd0, in_ready_i)
  `NTC_ASSERT_IMPL(a_temp_range, out_valid_i && !out_fault_i, (out_temp_i >= -16'sd4000) && (out_temp_i <= 16'sd15000))

endmodule

bind ntc_counts_to_temperature ntc_checker u_ntc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_temp_i  (out_o.temp_centi_c),
  .out_fault_i (out_o.sensor_fault)
);

// ===== sim/ntc_temperature_checker.sv =====
// ----------------------------------------------------------------------------
// NTC temperature checker
// Watches the count and temperature channels and the register port, predicts
// each temperature from the accepted count and compares it on arrival.
// ----------------------------------------------------------------------------
module ntc_temperature_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ntc_in_if           in_mon,
  ntc_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] temp;
    logic               fault;
  } temp_result_t;

  temp_result_t expected_temps[$];

  logic [15:0]        full_scale;
  logic signed [15:0] open_temp;
  logic               low_side;
  logic [19:0]        fixed_res;
  logic [15:0]        t0_ck;
  logic [13:0]        beta_k;
  logic [19:0]        r25_ohm;

  function automatic longint unsigned log2_q24(longint unsigned x);
    int p;
    longint unsigned m;
    longint unsigned f;
    p = 63;
    f = 0;
    while (p > 0 && x[p] == 1'b0) p--;
    m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        f = f | (64'd1 << (23 - i));
      end
    end
    return (longint'(p) << 24) | f;
  endfunction

  function automatic temp_result_t convert_count(logic [15:0] count);
    temp_result_t r;
    longint c, full, r25, diff, lnq, dnm, nmr, tk, temp;
    longint unsigned num, den, mag;
    c = longint'(count);
    full = longint'(full_scale);
    r25 = (r25_ohm == 0) ? 1 : longint'(r25_ohm);
    r.fault = 1'b1;
    r.temp = open_temp;
    if (c <= 2 || c >= full - 2) return r;
    if (low_side) begin
      num = longint'(fixed_res) * c;
      den = r25 * (full - c);
    end else begin
      num = longint'(fixed_res) * (full - c);
      den = r25 * c;
    end
    if (num == 0) return r;
    diff = longint'(log2_q24(num)) - longint'(log2_q24(den));
    mag = (diff < 0) ? -diff : diff;
    mag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
    lnq = (diff < 0) ? -longint'(mag) : longint'(mag);
    dnm = 100 * longint'(beta_k) * (64'sd1 << 24) + longint'(t0_ck) * lnq;
    nmr = 100 * longint'(t0_ck) * longint'(beta_k) * (64'sd1 << 24);
    if (dnm == 0) begin
      temp = 15000;
    end else if (dnm < 0) begin
      temp = -4000;
    end else begin
      tk = (nmr + dnm / 2) / dnm;
      temp = tk - 27315;
      if (temp < -4000) temp = -4000;
      if (temp > 15000) temp = 15000;
    end
    r.fault = 1'b0;
    r.temp = temp[15:0];
    return r;
  endfunction

  assign pending_o = expected_temps.size();

  always @(posedge clk_i or negedge rst_ni) begin
    temp_result_t exp_r;
    if (!rst_ni) begin
      full_scale <= 16'd4095;
      open_temp <= 16'sd15000;
      low_side <= 1'b1;
      fixed_res <= 20'd10000;
      t0_ck <= 16'd29815;
      beta_k <= 14'd3380;
      r25_ohm <= 20'd10000;
      errors_o <= 0;
      expected_temps.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ntc_pkg::ntc_reg_e'(paddr[4:2]))
          ntc_pkg::REG_FULL_SCALE: full_scale <= pwdata[15:0];
          ntc_pkg::REG_OPEN_TEMP: open_temp <= pwdata[15:0];
          ntc_pkg::REG_LOW_SIDE: low_side <= pwdata[0];
          ntc_pkg::REG_FIXED_RES: fixed_res <= pwdata[19:0];
          ntc_pkg::REG_NOM_TEMP: t0_ck <= pwdata[15:0];
          ntc_pkg::REG_BETA: beta_k <= pwdata[13:0];
          ntc_pkg::REG_NOM_RES: r25_ohm <= pwdata[19:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) expected_temps.push_back(convert_count(in_mon.adc_count));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_temps.size() == 0) begin
          $display("%0t: unexpected transfer, temp %0d fault %0b", $time,
                   out_mon.temp_centi_c, out_mon.sensor_fault);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = expected_temps.pop_front();
          if (exp_r.temp !== out_mon.temp_centi_c || exp_r.fault !== out_mon.sensor_fault) begin
            $display("%0t: mismatch, expected temp %0d fault %0b, actual temp %0d fault %0b",
                     $time, exp_r.temp, exp_r.fault, out_mon.temp_centi_c,
                     out_mon.sensor_fault);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/ntc_counts_to_temperature_tb.sv =====
// ----------------------------------------------------------------------------
// NTC counts to temperature testbench
// Drives ADC counts under several register settings with random gaps and
// output stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module ntc_counts_to_temperature_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        hold_out;
  logic        hold_go;
  int          out_gap;
  int          cycle_count = 0;
  int          errors;
  int          pending;

  ntc_in_if  in_bus ();
  ntc_out_if out_bus ();

  ntc_counts_to_temperature u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ntc_temperature_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit no_idle_stretch();
    return (cycle_count / 2500) % 4 == 1;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int g;
    if (!rst_ni) begin
      out_gap <= 0;
      out_bus.ready <= 1'b0;
    end else begin
      g = out_gap;
      if (out_bus.valid && out_bus.ready) g = no_idle_stretch() ? 0 : $urandom_range(0, 8);
      else if (g > 0) g--;
      out_gap <= g;
      out_bus.ready <= (g == 0) && !hold_out;
    end
  end

  initial begin
    hold_out <= 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  task automatic write_reg(ntc_pkg::ntc_reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_count(logic [15:0] count);
    int g;
    g = no_idle_stretch() ? 0 : $urandom_range(0, 8);
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.adc_count <= count;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_all(logic [15:0] fs, logic [15:0] ot, logic ls, logic [19:0] rf,
                         logic [15:0] t0, logic [13:0] bk, logic [19:0] r25);
    write_reg(ntc_pkg::REG_FULL_SCALE, 32'(fs));
    write_reg(ntc_pkg::REG_OPEN_TEMP, 32'(ot));
    write_reg(ntc_pkg::REG_LOW_SIDE, 32'(ls));
    write_reg(ntc_pkg::REG_FIXED_RES, 32'(rf));
    write_reg(ntc_pkg::REG_NOM_TEMP, 32'(t0));
    write_reg(ntc_pkg::REG_BETA, 32'(bk));
    write_reg(ntc_pkg::REG_NOM_RES, 32'(r25));
  endtask

  initial begin
    logic [15:0] fs;
    int top;
    logic [15:0] corner_counts [12];
    hold_go <= 1'b0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.adc_count <= '0;
    corner_counts = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd100, 16'd2048, 16'd4000,
                      16'd4092, 16'd4093, 16'd4095, 16'd65535};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (corner_counts[i]) send_count(corner_counts[i]);
    drain();

    // Zero fixed resistor, zero nominal resistance, zero beta, zero T0.
    set_all(16'd65535, 16'h8000, 1'b0, 20'd0, 16'd0, 14'd0, 20'd0);
    send_count(16'd3);
    send_count(16'd65532);
    send_count(16'd30000);
    drain();
    set_all(16'd65535, 16'h7fff, 1'b1, 20'hfffff, 16'd0, 14'd3380, 20'd0);
    send_count(16'd3);
    send_count(16'd65532);
    drain();
    set_all(16'd4095, 16'd0, 1'b1, 20'd10000, 16'd29815, 14'd0, 20'd10000);
    send_count(16'd100);
    send_count(16'd2000);
    send_count(16'd2048);
    send_count(16'd4000);
    drain();
    set_all(16'd10, 16'd1234, 1'b0, 20'd1, 16'd65535, 14'h3fff, 20'hfffff);
    send_count(16'd5);
    send_count(16'd9);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: fs = 16'd65535;
        1: fs = 16'($urandom_range(16, 4096));
        2: fs = 16'($urandom_range(16, 65535));
        default: fs = 16'($urandom_range(0, 20));
      endcase
      set_all(fs, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
              ($urandom_range(0, 9) == 0) ? 20'hfffff : 20'($urandom_range(1, 1000000)),
              ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535)) :
                                            16'($urandom_range(20000, 40000)),
              ($urandom_range(0, 9) == 0) ? 14'($urandom_range(0, 16383)) :
                                            14'($urandom_range(1000, 10000)),
              ($urandom_range(0, 9) == 0) ? 20'hfffff : 20'($urandom_range(1, 1000000)));
      top = (int'(fs) + 3 > 65535) ? 65535 : int'(fs) + 3;
      if (ph == 0) hold_go <= 1'b1;
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(0, 4) == 0) send_count(16'($urandom_range(0, 65535)));
        else send_count(16'($urandom_range(0, top)));
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
